// File: hw/rtl/ppep_pkg.sv
package ppep_pkg;

   localparam int PROC_SLOTS  = 64;
   localparam int ALLOC_SLOTS = 1024;
   localparam int PW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
   localparam int AW = (ALLOC_SLOTS > 1) ? $clog2(ALLOC_SLOTS) : 1;

   localparam logic [2:0] CMD_ADD      = 3'd0;
   localparam logic [2:0] CMD_REMOVE   = 3'd1;
   localparam logic [2:0] CMD_ALLOC    = 3'd2;
   localparam logic [2:0] CMD_ARET     = 3'd3;
   localparam logic [2:0] CMD_FREE     = 3'd4;
   localparam logic [2:0] CMD_OTHER    = 3'd5;
   localparam logic [2:0] CMD_READ     = 3'd6;

   localparam logic [2:0] SEL_SCHED    = 3'd0;
   localparam logic [2:0] SEL_UP       = 3'd1;
   localparam logic [2:0] SEL_DOWN     = 3'd2;
   localparam logic [2:0] SEL_LOCK     = 3'd3;
   localparam logic [2:0] SEL_UNLOCK   = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_BAD      = 2'd3;

   // one row of per-process counters
   typedef struct packed {
      logic [31:0] alloc_calls;
      logic [31:0] free_calls;
      logic [63:0] alloc_bytes;
      logic [63:0] freed_bytes;
      logic [31:0] sched_calls;
      logic [31:0] up_calls;
      logic [31:0] down_calls;
      logic [31:0] lock_calls;
      logic [31:0] unlock_calls;
   } row_type;

   // result of a scan over the allocation table
   typedef struct packed {
      logic          hit;
      logic [AW-1:0] hit_idx;
      logic          free_found;
      logic [AW-1:0] free_idx;
      logic [31:0]   len;
   } scan_type;

endpackage

// File: hw/rtl/per_process_event_profiler.sv
// channel  | direction | ports
// request  | in        | req_valid, req_ready, req_cmd .. req_slot
// response | out       | rsp_valid, rsp_ready, rsp_status .. rsp_unlock_calls
// After accept the pid table is walked, one entry a cycle; then the row is read and updated,
// and the response is registered.
// Alloc return and free of a nonzero address add a walk of the allocation map.
// One beat is in work at a time; req_ready is high only while idle.
// After reset req_ready stays low while the map is cleared.
// A held response beat blocks the next item until rsp_ready takes it.
module per_process_event_profiler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [21:0] req_pid,
   input  logic [31:0] req_size,
   input  logic [63:0] req_address,
   input  logic [2:0]  req_counter_select,
   input  logic [5:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_slot_valid,
   output logic [21:0] rsp_slot_pid,
   output logic [31:0] rsp_alloc_calls,
   output logic [31:0] rsp_free_calls,
   output logic [63:0] rsp_alloc_bytes,
   output logic [63:0] rsp_freed_bytes,
   output logic [31:0] rsp_sched_calls,
   output logic [31:0] rsp_up_calls,
   output logic [31:0] rsp_down_calls,
   output logic [31:0] rsp_lock_calls,
   output logic [31:0] rsp_unlock_calls
);
   localparam int PW = ppep_pkg::PW;
   localparam logic [PW:0] PLAST = (PW+1)'(ppep_pkg::PROC_SLOTS);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PSCAN = 7'b0000010,
      S_ASCAN = 7'b0000100,
      S_ARD   = 7'b0001000,
      S_AWAIT = 7'b0010000,
      S_EXEC  = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]  cmd_ff;
   logic [21:0] pid_ff;
   logic [31:0] size_ff;
   logic [63:0] addr_ff;
   logic [2:0]  sel_ff;
   logic [5:0]  slot_ff;

   logic [ppep_pkg::PROC_SLOTS-1:0] pvalid_ff;
   logic [21:0] pid_mem [ppep_pkg::PROC_SLOTS];
   ppep_pkg::row_type row_mem [ppep_pkg::PROC_SLOTS];

   // process scan
   logic [PW:0]   pidx_ff;
   logic          prd_ok_ff;
   logic [PW-1:0] prd_idx_ff;
   logic [21:0]   prd_pid_ff;
   logic          phit_ff, pfree_ok_ff;
   logic [PW-1:0] phit_idx_ff, pfree_idx_ff;

   logic          a_start, a_done, a_wr_en, a_wr_valid, a_init_done;
   logic [ppep_pkg::AW-1:0] a_wr_idx;
   ppep_pkg::scan_type a_scan;

   ppep_pkg::row_type row_rd_ff, row_new;
   logic          row_wr;
   logic [PW-1:0] row_idx;
   logic [PW-1:0] rd_addr;
   logic [21:0]   pid_rd_ff;

   logic [1:0]  status_ff, status_in;
   logic        out_valid_ff;
   logic        rvalid_ff, rvalid_in;
   ppep_pkg::row_type out_row_ff, out_row_in;
   logic [21:0] out_pid_ff, out_pid_in;

   logic        accept;
   logic        need_alloc;
   logic        read_in_range;

   assign accept    = req_valid && req_ready;
   assign req_ready = state_ff == S_IDLE && a_init_done;
   assign need_alloc = cmd_ff == ppep_pkg::CMD_ARET ||
                       (cmd_ff == ppep_pkg::CMD_FREE && addr_ff != 64'd0);
   assign read_in_range = {26'd0, slot_ff} < 32'(ppep_pkg::PROC_SLOTS);
   assign row_idx = (cmd_ff == ppep_pkg::CMD_READ) ? PW'(slot_ff) :
                    (cmd_ff == ppep_pkg::CMD_ADD) ? pfree_idx_ff : phit_idx_ff;
   assign rd_addr = (state_ff == S_PSCAN) ? pidx_ff[PW-1:0] : row_idx;

   always_ff @(posedge clock) begin
      pid_rd_ff  <= pid_mem[rd_addr];
      row_rd_ff  <= row_mem[row_idx];
      if (row_wr) row_mem[row_idx] <= row_new;
      if (state_ff == S_EXEC && cmd_ff == ppep_pkg::CMD_ADD && !phit_ff && pfree_ok_ff)
         pid_mem[pfree_idx_ff] <= pid_ff;
   end
   assign prd_pid_ff = pid_rd_ff;

   ppep_alloc_table u_alloc (
      .clock     (clock),
      .reset     (reset),
      .start     (a_start),
      .addr      (addr_ff),
      .done      (a_done),
      .scan      (a_scan),
      .init_done (a_init_done),
      .wr_en     (a_wr_en),
      .wr_idx    (a_wr_idx),
      .wr_valid  (a_wr_valid),
      .wr_addr   (addr_ff),
      .wr_len    (size_ff)
   );

   always_comb begin
      state_in   = state_ff;
      a_start    = 1'b0;
      a_wr_en    = 1'b0;
      a_wr_idx   = a_scan.free_idx;
      a_wr_valid = 1'b1;
      row_wr     = 1'b0;
      row_new    = row_rd_ff;
      status_in  = status_ff;
      rvalid_in  = 1'b0;
      out_row_in = '0;
      out_pid_in = '0;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_PSCAN;
         S_PSCAN: if (!prd_ok_ff && pidx_ff == PLAST) begin
            if (need_alloc) begin
               a_start  = 1'b1;
               state_in = S_ASCAN;
            end else state_in = S_ARD;
         end
         S_ASCAN: if (a_done) state_in = S_ARD;
         S_ARD:   state_in = S_AWAIT; // row read in flight
         S_AWAIT: state_in = S_EXEC;
         S_EXEC: begin
            state_in  = S_RESP;
            status_in = ppep_pkg::ST_OK;
            case (cmd_ff)
               ppep_pkg::CMD_ADD: begin
                  if (!phit_ff) begin
                     if (pfree_ok_ff) begin
                        row_wr  = 1'b1;
                        row_new = '0;
                     end else status_in = ppep_pkg::ST_FULL;
                  end
               end
               ppep_pkg::CMD_REMOVE:
                  if (!phit_ff) status_in = ppep_pkg::ST_NOTFOUND;
               ppep_pkg::CMD_ALLOC: begin
                  if (phit_ff) begin
                     row_wr = 1'b1;
                     row_new.alloc_calls = row_rd_ff.alloc_calls + 32'd1;
                     row_new.alloc_bytes = row_rd_ff.alloc_bytes + {32'd0, size_ff};
                  end else status_in = ppep_pkg::ST_NOTFOUND;
               end
               ppep_pkg::CMD_ARET: begin
                  if (addr_ff == 64'd0) status_in = ppep_pkg::ST_BAD;
                  else if (a_scan.free_found) a_wr_en = 1'b1;
                  else status_in = ppep_pkg::ST_FULL;
               end
               ppep_pkg::CMD_FREE: begin
                  if (phit_ff) begin
                     row_wr = 1'b1;
                     row_new.free_calls = row_rd_ff.free_calls + 32'd1;
                  end
                  if (addr_ff == 64'd0) status_in = ppep_pkg::ST_BAD;
                  else if (a_scan.hit) begin
                     a_wr_en    = 1'b1;
                     a_wr_idx   = a_scan.hit_idx;
                     a_wr_valid = 1'b0;
                     if (phit_ff)
                        row_new.freed_bytes = row_rd_ff.freed_bytes + {32'd0, a_scan.len};
                  end else status_in = ppep_pkg::ST_NOTFOUND;
               end
               ppep_pkg::CMD_OTHER: begin
                  if (sel_ff > ppep_pkg::SEL_UNLOCK) status_in = ppep_pkg::ST_BAD;
                  else if (!phit_ff) status_in = ppep_pkg::ST_NOTFOUND;
                  else begin
                     row_wr = 1'b1;
                     case (sel_ff)
                        ppep_pkg::SEL_SCHED:
                           row_new.sched_calls = row_rd_ff.sched_calls + 32'd1;
                        ppep_pkg::SEL_UP:
                           row_new.up_calls = row_rd_ff.up_calls + 32'd1;
                        ppep_pkg::SEL_DOWN:
                           row_new.down_calls = row_rd_ff.down_calls + 32'd1;
                        ppep_pkg::SEL_LOCK:
                           row_new.lock_calls = row_rd_ff.lock_calls + 32'd1;
                        default: row_new.unlock_calls = row_rd_ff.unlock_calls + 32'd1;
                     endcase
                  end
               end
               ppep_pkg::CMD_READ: begin
                  if (!read_in_range) status_in = ppep_pkg::ST_NOTFOUND;
                  else if (pvalid_ff[PW'(slot_ff)]) begin
                     rvalid_in  = 1'b1;
                     out_row_in = row_rd_ff;
                     out_pid_in = pid_rd_ff;
                  end
               end
               default: status_in = ppep_pkg::ST_BAD;
            endcase
         end
         S_RESP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pvalid_ff    <= '0;
         out_valid_ff <= 1'b0;
         prd_ok_ff    <= 1'b0;
         pidx_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_EXEC) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         if (state_ff == S_EXEC) begin
            if (cmd_ff == ppep_pkg::CMD_ADD && !phit_ff && pfree_ok_ff)
               pvalid_ff[pfree_idx_ff] <= 1'b1;
            if (cmd_ff == ppep_pkg::CMD_REMOVE && phit_ff)
               pvalid_ff[phit_idx_ff] <= 1'b0;
         end
         if (accept) pidx_ff <= '0;
         else if (state_ff == S_PSCAN && pidx_ff != PLAST) pidx_ff <= pidx_ff + 1'b1;
         prd_ok_ff <= state_ff == S_PSCAN && pidx_ff != PLAST;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         pid_ff  <= req_pid;
         size_ff <= req_size;
         addr_ff <= req_address;
         sel_ff  <= req_counter_select;
         slot_ff <= req_slot;
         phit_ff     <= 1'b0;
         pfree_ok_ff <= 1'b0;
      end else if (prd_ok_ff) begin
         if (pvalid_ff[prd_idx_ff] && prd_pid_ff == pid_ff && !phit_ff) begin
            phit_ff     <= 1'b1;
            phit_idx_ff <= prd_idx_ff;
         end
         if (!pvalid_ff[prd_idx_ff] && !pfree_ok_ff) begin
            pfree_ok_ff  <= 1'b1;
            pfree_idx_ff <= prd_idx_ff;
         end
      end
      prd_idx_ff <= pidx_ff[PW-1:0];
      if (state_ff == S_EXEC) begin
         status_ff  <= status_in;
         rvalid_ff  <= rvalid_in;
         out_row_ff <= out_row_in;
         out_pid_ff <= out_pid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot_valid   = rvalid_ff;
   assign rsp_slot_pid     = out_pid_ff;
   assign rsp_alloc_calls  = out_row_ff.alloc_calls;
   assign rsp_free_calls   = out_row_ff.free_calls;
   assign rsp_alloc_bytes  = out_row_ff.alloc_bytes;
   assign rsp_freed_bytes  = out_row_ff.freed_bytes;
   assign rsp_sched_calls  = out_row_ff.sched_calls;
   assign rsp_up_calls     = out_row_ff.up_calls;
   assign rsp_down_calls   = out_row_ff.down_calls;
   assign rsp_lock_calls   = out_row_ff.lock_calls;
   assign rsp_unlock_calls = out_row_ff.unlock_calls;

   a_resp_in_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_RESP) else $error("response outside response state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while response held");
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_slot_valid) |-> rsp_alloc_calls == 32'd0)
      else $error("data on empty read");
   a_exec_resp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> rsp_valid) else $error("missing response");
endmodule

// File: hw/rtl/ppep_alloc_table.sv
// Allocation map: one entry per cycle scan, lowest hit and lowest free slot.
// After reset the map is cleared one entry a cycle; init_done rises when it is empty.
module ppep_alloc_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           addr,
   output logic                  done,
   output ppep_pkg::scan_type    scan,
   output logic                  init_done,
   input  logic                  wr_en,
   input  logic [ppep_pkg::AW-1:0] wr_idx,
   input  logic                  wr_valid,
   input  logic [63:0]           wr_addr,
   input  logic [31:0]           wr_len
);
   localparam int AW = ppep_pkg::AW;
   localparam logic [AW:0] LAST = (AW+1)'(ppep_pkg::ALLOC_SLOTS);

   // entry word: valid, length, address
   logic [96:0] entry_mem [ppep_pkg::ALLOC_SLOTS];

   logic          busy_ff, busy_in;
   logic [AW:0]   idx_ff, idx_in;
   logic          rd_ok_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [96:0]   rd_word_ff;
   logic [63:0]   rd_addr;
   logic [31:0]   rd_len;
   logic          rd_valid;
   logic          clr_ff;
   logic [AW-1:0] clr_idx_ff;
   ppep_pkg::scan_type scan_ff, scan_in;
   logic          done_ff, done_in;

   always_ff @(posedge clock) begin
      if (clr_ff) entry_mem[clr_idx_ff] <= '0;
      else if (wr_en) entry_mem[wr_idx] <= {wr_valid, wr_len, wr_addr};
      rd_word_ff <= entry_mem[idx_ff[AW-1:0]];
   end

   assign rd_valid = rd_word_ff[96];
   assign rd_len   = rd_word_ff[95:64];
   assign rd_addr  = rd_word_ff[63:0];

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      scan_in = scan_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         scan_in = '0;
      end else if (busy_ff) begin
         if (idx_ff != LAST) idx_in = idx_ff + 1'b1;
      end
      // evaluate the entry read in the previous cycle
      if (rd_ok_ff && !start) begin
         if (rd_valid && rd_addr == addr && !scan_in.hit) begin
            scan_in.hit     = 1'b1;
            scan_in.hit_idx = rd_idx_ff;
            scan_in.len     = rd_len;
         end
         if (!rd_valid && !scan_in.free_found) begin
            scan_in.free_found = 1'b1;
            scan_in.free_idx   = rd_idx_ff;
         end
         if (rd_idx_ff == AW'(ppep_pkg::ALLOC_SLOTS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
         busy_ff    <= 1'b0;
         idx_ff     <= '0;
         rd_ok_ff   <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         if (clr_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == AW'(ppep_pkg::ALLOC_SLOTS - 1)) clr_ff <= 1'b0;
         end
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         rd_ok_ff <= busy_ff && !start && idx_ff != LAST;
         done_ff  <= done_in;
      end
      rd_idx_ff   <= idx_ff[AW-1:0];
      scan_ff     <= scan_in;
   end

   assign done      = done_ff;
   assign scan      = scan_ff;
   assign init_done = !clr_ff;
endmodule

// File: test/per_process_event_profiler_test.sv
module per_process_event_profiler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_UNUSED  = 3'd7;
   localparam logic [2:0] SEL_INVALID = 3'd7;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [21:0] pid;
      logic [31:0] size;
      logic [63:0] address;
      logic [2:0]  sel;
      logic [5:0]  slot;
   } event_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        slot_valid;
      logic [21:0] slot_pid;
      ppep_pkg::row_type row;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_cmd = '0;
   logic [21:0] req_pid = '0;
   logic [31:0] req_size = '0;
   logic [63:0] req_address = '0;
   logic [2:0]  req_counter_select = '0;
   logic [5:0]  req_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_slot_valid;
   logic [21:0] rsp_slot_pid;
   logic [31:0] rsp_alloc_calls, rsp_free_calls;
   logic [63:0] rsp_alloc_bytes, rsp_freed_bytes;
   logic [31:0] rsp_sched_calls, rsp_up_calls, rsp_down_calls;
   logic [31:0] rsp_lock_calls, rsp_unlock_calls;

   per_process_event_profiler i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the profiler tables
   logic        proc_live [ppep_pkg::PROC_SLOTS];
   logic [21:0] proc_id [ppep_pkg::PROC_SLOTS];
   ppep_pkg::row_type proc_row [ppep_pkg::PROC_SLOTS];
   logic        map_live [ppep_pkg::ALLOC_SLOTS];
   logic [63:0] map_addr [ppep_pkg::ALLOC_SLOTS];
   logic [31:0] map_len [ppep_pkg::ALLOC_SLOTS];

   event_type  pending_events[$];
   report_type expected_reports[$];
   int      send_idle_pct = 0;
   int      take_idle_pct = 0;
   int      take_hold = 0;
   int      quiet_cycles = 0;
   bit      failed = 1'b0;
   bit      req_fire = 1'b0;
   logic [21:0] pid_pool [96];
   logic [63:0] addr_pool [64];

   function automatic int lookup_proc(input logic [21:0] pid);
      for (int i = 0; i < ppep_pkg::PROC_SLOTS; i++)
         if (proc_live[i] && proc_id[i] == pid) return i;
      return -1;
   endfunction

   function automatic int lookup_alloc(input logic [63:0] addr);
      for (int i = 0; i < ppep_pkg::ALLOC_SLOTS; i++)
         if (map_live[i] && map_addr[i] == addr) return i;
      return -1;
   endfunction

   function automatic report_type apply_event(input event_type ev);
      report_type rep;
      int s;
      int m;
      rep = '0;
      rep.status = ppep_pkg::ST_OK;
      s = lookup_proc(ev.pid);
      case (ev.cmd)
         ppep_pkg::CMD_ADD: begin
            if (s < 0) begin
               rep.status = ppep_pkg::ST_FULL;
               for (int i = 0; i < ppep_pkg::PROC_SLOTS; i++) begin
                  if (!proc_live[i]) begin
                     proc_live[i] = 1'b1;
                     proc_id[i] = ev.pid;
                     proc_row[i] = '0;
                     rep.status = ppep_pkg::ST_OK;
                     break;
                  end
               end
            end
         end
         ppep_pkg::CMD_REMOVE: begin
            if (s < 0) rep.status = ppep_pkg::ST_NOTFOUND;
            else proc_live[s] = 1'b0;
         end
         ppep_pkg::CMD_ALLOC: begin
            if (s < 0) rep.status = ppep_pkg::ST_NOTFOUND;
            else begin
               proc_row[s].alloc_calls += 32'd1;
               proc_row[s].alloc_bytes += 64'(ev.size);
            end
         end
         ppep_pkg::CMD_ARET: begin
            if (ev.address == '0) rep.status = ppep_pkg::ST_BAD;
            else begin
               rep.status = ppep_pkg::ST_FULL;
               for (int i = 0; i < ppep_pkg::ALLOC_SLOTS; i++) begin
                  if (!map_live[i]) begin
                     map_live[i] = 1'b1;
                     map_addr[i] = ev.address;
                     map_len[i] = ev.size;
                     rep.status = ppep_pkg::ST_OK;
                     break;
                  end
               end
            end
         end
         ppep_pkg::CMD_FREE: begin
            if (s >= 0) proc_row[s].free_calls += 32'd1;
            if (ev.address == '0) rep.status = ppep_pkg::ST_BAD;
            else begin
               m = lookup_alloc(ev.address);
               if (m < 0) rep.status = ppep_pkg::ST_NOTFOUND;
               else begin
                  if (s >= 0) proc_row[s].freed_bytes += 64'(map_len[m]);
                  map_live[m] = 1'b0;
               end
            end
         end
         ppep_pkg::CMD_OTHER: begin
            if (ev.sel > ppep_pkg::SEL_UNLOCK) rep.status = ppep_pkg::ST_BAD;
            else if (s < 0) rep.status = ppep_pkg::ST_NOTFOUND;
            else case (ev.sel)
               ppep_pkg::SEL_SCHED: proc_row[s].sched_calls += 32'd1;
               ppep_pkg::SEL_UP:    proc_row[s].up_calls += 32'd1;
               ppep_pkg::SEL_DOWN:  proc_row[s].down_calls += 32'd1;
               ppep_pkg::SEL_LOCK:  proc_row[s].lock_calls += 32'd1;
               default:             proc_row[s].unlock_calls += 32'd1;
            endcase
         end
         ppep_pkg::CMD_READ: begin
            if (proc_live[ev.slot]) begin
               rep.slot_valid = 1'b1;
               rep.slot_pid = proc_id[ev.slot];
               rep.row = proc_row[ev.slot];
            end
         end
         default: rep.status = ppep_pkg::ST_BAD;
      endcase
      return rep;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
         failed = 1'b1;
      end
   endtask

   // sample on the rising edge
   always @(posedge clock) begin
      report_type want;
      req_fire = req_valid && req_ready && !reset;
      if (req_fire)
         expected_reports.push_back(apply_event({req_cmd, req_pid, req_size, req_address,
                                                 req_counter_select, req_slot}));
      if (rsp_valid && rsp_ready && !reset) begin
         if (expected_reports.size() == 0) begin
            $display("%0t unexpected beat: expected none actual status %h",
                     $realtime, rsp_status);
            failed = 1'b1;
         end else begin
            want = expected_reports.pop_front();
            compare_field("status", want.status, rsp_status);
            compare_field("slot_valid", want.slot_valid, rsp_slot_valid);
            compare_field("slot_pid", want.slot_pid, rsp_slot_pid);
            compare_field("alloc_calls", want.row.alloc_calls, rsp_alloc_calls);
            compare_field("free_calls", want.row.free_calls, rsp_free_calls);
            compare_field("alloc_bytes", want.row.alloc_bytes, rsp_alloc_bytes);
            compare_field("freed_bytes", want.row.freed_bytes, rsp_freed_bytes);
            compare_field("sched_calls", want.row.sched_calls, rsp_sched_calls);
            compare_field("up_calls", want.row.up_calls, rsp_up_calls);
            compare_field("down_calls", want.row.down_calls, rsp_down_calls);
            compare_field("lock_calls", want.row.lock_calls, rsp_lock_calls);
            compare_field("unlock_calls", want.row.unlock_calls, rsp_unlock_calls);
         end
      end
      if (req_fire || (rsp_valid && rsp_ready) || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // drive on the falling edge
   always @(negedge clock) begin
      event_type ev;
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            ev = pending_events.pop_front();
            req_cmd <= ev.cmd;
            req_pid <= ev.pid;
            req_size <= ev.size;
            req_address <= ev.address;
            req_counter_select <= ev.sel;
            req_slot <= ev.slot;
            req_valid <= 1'b1;
         end else
            req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (take_hold > 0) begin
         rsp_ready <= 1'b0;
         take_hold--;
      end else
         rsp_ready <= ($urandom_range(99) >= take_idle_pct);
   end

   task automatic queue_event(input logic [2:0] cmd, input logic [21:0] pid,
                              input logic [31:0] size, input logic [63:0] addr,
                              input logic [2:0] sel, input logic [5:0] slot);
      pending_events.push_back({cmd, pid, size, addr, sel, slot});
   endtask

   task automatic drain;
      while (pending_events.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_random;
      logic [2:0]  cmd;
      logic [63:0] addr;
      int pick;
      pick = $urandom_range(99);
      // keep the slow map walks to about a quarter of the traffic
      if (pick < 10) cmd = ppep_pkg::CMD_ADD;
      else if (pick < 16) cmd = ppep_pkg::CMD_REMOVE;
      else if (pick < 32) cmd = ppep_pkg::CMD_ALLOC;
      else if (pick < 45) cmd = ppep_pkg::CMD_ARET;
      else if (pick < 58) cmd = ppep_pkg::CMD_FREE;
      else if (pick < 78) cmd = ppep_pkg::CMD_OTHER;
      else if (pick < 97) cmd = ppep_pkg::CMD_READ;
      else cmd = CMD_UNUSED;
      pick = $urandom_range(99);
      if (pick < 5) addr = '0;
      else if (pick < 15) addr = {$urandom, $urandom};
      else addr = addr_pool[$urandom_range(63)];
      queue_event(cmd,
                  ($urandom_range(19) == 0) ? 22'($urandom) : pid_pool[$urandom_range(95)],
                  ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : 32'($urandom),
                  addr,
                  ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4)),
                  6'($urandom_range(63)));
   endtask

   initial begin
      logic [63:0] fill_addr [$];
      int map_count;
      for (int i = 0; i < ppep_pkg::PROC_SLOTS; i++) proc_live[i] = 1'b0;
      for (int i = 0; i < ppep_pkg::ALLOC_SLOTS; i++) map_live[i] = 1'b0;
      for (int i = 0; i < 96; i++) pid_pool[i] = 22'($urandom);
      pid_pool[0] = '0;
      pid_pool[1] = '1;
      for (int i = 0; i < 64; i++) addr_pool[i] = {$urandom, $urandom};
      addr_pool[0] = '1;
      addr_pool[1] = 64'd1;
      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed corners
      send_idle_pct = 34;
      take_idle_pct = 76;
      queue_event(ppep_pkg::CMD_ADD, '0, '0, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_ADD, '1, '1, '1, ppep_pkg::SEL_SCHED, '1);
      queue_event(ppep_pkg::CMD_ADD, '0, '0, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_ALLOC, '0, '1, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_ALLOC, 22'h1234, 32'd7, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_ARET, '0, 32'd9, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_ARET, '1, '1, '1, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_ARET, 22'h1234, 32'd5, 64'd1, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_FREE, '0, '0, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_FREE, '0, '0, 64'h55, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_FREE, '1, '0, '1, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_FREE, 22'h1234, '0, 64'd1, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_OTHER, '1, '0, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_OTHER, '1, '0, '0, ppep_pkg::SEL_UP, '0);
      queue_event(ppep_pkg::CMD_OTHER, '1, '0, '0, ppep_pkg::SEL_DOWN, '0);
      queue_event(ppep_pkg::CMD_OTHER, '1, '0, '0, ppep_pkg::SEL_LOCK, '0);
      queue_event(ppep_pkg::CMD_OTHER, '1, '0, '0, ppep_pkg::SEL_UNLOCK, '0);
      queue_event(ppep_pkg::CMD_OTHER, '1, '0, '0, SEL_INVALID, '0);
      queue_event(ppep_pkg::CMD_OTHER, 22'h1234, '0, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(CMD_UNUSED, '1, '1, '1, SEL_INVALID, '1);
      queue_event(ppep_pkg::CMD_READ, '0, '0, '0, ppep_pkg::SEL_SCHED, 6'd0);
      queue_event(ppep_pkg::CMD_READ, '0, '0, '0, ppep_pkg::SEL_SCHED, 6'd1);
      queue_event(ppep_pkg::CMD_READ, '0, '0, '0, ppep_pkg::SEL_SCHED, '1);
      queue_event(ppep_pkg::CMD_REMOVE, '0, '0, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_REMOVE, 22'h1234, '0, '0, ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_READ, '0, '0, '0, ppep_pkg::SEL_SCHED, 6'd0);
      for (int i = 0; i < 25; i++) queue_random();
      drain();

      send_idle_pct = 76;
      take_idle_pct = 34;
      for (int i = 0; i < 25; i++) queue_random();
      drain();

      send_idle_pct = 0;
      take_idle_pct = 0;
      // hold the response side while requests keep coming, so the input stalls
      take_hold = 3000;
      for (int i = 0; i < 20; i++) queue_random();
      // overfill the process table and read some of it back
      for (int i = 0; i < ppep_pkg::PROC_SLOTS + 2; i++)
         queue_event(ppep_pkg::CMD_ADD, 22'($urandom), '0, '0, ppep_pkg::SEL_SCHED, '0);
      for (int i = 0; i < 3; i++)
         queue_event(ppep_pkg::CMD_READ, '0, '0, '0, ppep_pkg::SEL_SCHED, 6'(i));
      queue_event(ppep_pkg::CMD_READ, '0, '0, '0, ppep_pkg::SEL_SCHED, '1);
      drain();

      // overfill the allocation map, then free part of it
      map_count = 0;
      for (int i = 0; i < ppep_pkg::ALLOC_SLOTS; i++)
         if (map_live[i]) map_count++;
      for (int i = 0; i < ppep_pkg::ALLOC_SLOTS - map_count + 2; i++) begin
         fill_addr.push_back({$urandom, $urandom} | 64'd1);
         queue_event(ppep_pkg::CMD_ARET, '0, 32'($urandom), fill_addr[i],
                     ppep_pkg::SEL_SCHED, '0);
      end
      queue_event(ppep_pkg::CMD_ADD, pid_pool[2], '0, '0, ppep_pkg::SEL_SCHED, '0);
      for (int i = 0; i < 10; i++)
         queue_event(ppep_pkg::CMD_FREE, pid_pool[2], '0, fill_addr[i],
                     ppep_pkg::SEL_SCHED, '0);
      queue_event(ppep_pkg::CMD_READ, '0, '0, '0, ppep_pkg::SEL_SCHED, 6'd0);
      drain();

      repeat (1200) @(posedge clock);
      if (failed)
         $display("FAIL");
      else
         $display("PASS");
      $finish;
   end
endmodule
